// ===== rtl/http_chunked_body_decoder_core_macros.svh =====
// ----------------------------------------------------------------------------
// Chunked body decoder assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_CORE_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_CORE_MACROS_SVH

// same-cycle implication
`define HCBD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HCBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// Chunked body decoder package
// Widths, character codes, result kinds, item types and the hex decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hcbd_pkg;

    localparam int SIZE_BITS   = 64;
    localparam int LENGTH_BITS = 32;
    localparam int TOTAL_BITS  = 64;
    localparam int CFG_BITS    = 32;
    localparam int DIGIT_BITS  = 4;
    localparam int OUT_LEN_BITS = 32;

    localparam logic [CFG_BITS-1:0]   CFG_RESET = CFG_BITS'(1048576);
    localparam logic [TOTAL_BITS-1:0] LEN_MAX   =
        TOTAL_BITS'((65'd1 << LENGTH_BITS) - 65'd1);

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // trailer CR LF matcher: start counts the size line CR LF, done at CR LF CR LF
    localparam logic [2:0] TM_NONE  = 3'd0;
    localparam logic [2:0] TM_CR    = 3'd1;
    localparam logic [2:0] TM_START = 3'd2;
    localparam logic [2:0] TM_CR2   = 3'd3;
    localparam logic [2:0] TM_DONE  = 3'd4;

    typedef enum logic [1:0] {
        KIND_BYTE      = 2'd0,
        KIND_END       = 2'd1,
        KIND_MALFORMED = 2'd2,
        KIND_TOO_LARGE = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       restart;
    } in_item_t;

    typedef struct packed {
        kind_t                   kind;
        logic [7:0]              data_byte;
        logic [OUT_LEN_BITS-1:0] body_length;
    } out_item_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } result_t;

    typedef struct packed {
        logic                  ok;
        logic [DIGIT_BITS-1:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] b);
        hex_t h;
        h.ok    = 1'b1;
        h.value = '0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            h.value = DIGIT_BITS'(b - 8'h30);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            h.value = DIGIT_BITS'(b - 8'h57);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            h.value = DIGIT_BITS'(b - 8'h37);
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

// ===== rtl/hcbd_in_stage.sv =====
// ----------------------------------------------------------------------------
// Chunked body decoder input register
// Holds one accepted item until the parser consumes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcbd_in_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  hcbd_pkg::in_item_t in_item,
    input  logic             consume,
    output logic             held_valid,
    output hcbd_pkg::in_item_t held_item
);

    logic               valid_reg;
    logic               valid_next;
    hcbd_pkg::in_item_t item_reg;

    assign in_ready   = !valid_reg || consume;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (consume)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== rtl/hcbd_parser.sv =====
// ----------------------------------------------------------------------------
// Chunked body decoder parser
// Per-byte state update and result selection; holds the limit register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcbd_parser (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [hcbd_pkg::CFG_BITS-1:0]      cfg_wr_data,
    input  logic                               step,
    input  hcbd_pkg::in_item_t                 item,
    output hcbd_pkg::result_t                  res
);

    typedef enum logic [2:0] {
        PH_SIZE    = 3'd0,
        PH_DATA    = 3'd1,
        PH_CR      = 3'd2,
        PH_LF      = 3'd3,
        PH_TRAILER = 3'd4
    } phase_t;

    localparam int SB = hcbd_pkg::SIZE_BITS;
    localparam int TB = hcbd_pkg::TOTAL_BITS;

    phase_t                             phase_reg, phase_next;
    logic [SB-1:0]                      acc_reg, acc_next;
    logic                               ovf_reg, ovf_next;
    logic                               seen_reg, seen_next;
    logic                               ended_reg, ended_next;
    logic                               crp_reg, crp_next;
    logic [TB-1:0]                      left_reg, left_next;
    logic [TB-1:0]                      total_reg, total_next;
    logic [2:0]                         tm_reg, tm_next;
    logic                               err_reg, err_next;
    logic [hcbd_pkg::CFG_BITS-1:0]      cfg_reg;

    logic [TB-1:0]                      limit;
    logic [TB-1:0]                      room;
    logic [7:0]                         b;
    hcbd_pkg::hex_t                     hex;
    logic [2:0]                         tm_step;

    assign b     = item.byte_in;
    assign hex   = hcbd_pkg::hex_decode(b);
    assign limit = (TB'(cfg_reg) > hcbd_pkg::LEN_MAX) ? hcbd_pkg::LEN_MAX : TB'(cfg_reg);
    assign room  = limit - total_reg;

    always_comb
    begin
        if (b == hcbd_pkg::CHAR_CR)
        begin
            tm_step = (tm_reg == hcbd_pkg::TM_START) ? hcbd_pkg::TM_CR2 : hcbd_pkg::TM_CR;
        end
        else if (b == hcbd_pkg::CHAR_LF &&
                 (tm_reg == hcbd_pkg::TM_CR || tm_reg == hcbd_pkg::TM_CR2))
        begin
            tm_step = tm_reg + 3'd1;
        end
        else
        begin
            tm_step = hcbd_pkg::TM_NONE;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        seen_next  = seen_reg;
        ended_next = ended_reg;
        crp_next   = crp_reg;
        left_next  = left_reg;
        total_next = total_reg;
        tm_next    = tm_reg;
        err_next   = err_reg;
        res        = '0;

        if (step)
        begin
            if (item.restart)
            begin
                phase_next = PH_SIZE;
                acc_next   = '0;
                ovf_next   = 1'b0;
                seen_next  = 1'b0;
                ended_next = 1'b0;
                crp_next   = 1'b0;
                left_next  = '0;
                total_next = '0;
                tm_next    = hcbd_pkg::TM_START;
                err_next   = 1'b0;
            end
            else if (!err_reg)
            begin
                unique case (phase_reg)
                    PH_SIZE:
                    begin
                        if (crp_reg && b == hcbd_pkg::CHAR_LF)
                        begin
                            acc_next   = '0;
                            ovf_next   = 1'b0;
                            seen_next  = 1'b0;
                            ended_next = 1'b0;
                            crp_next   = 1'b0;
                            if (!seen_reg || ovf_reg)
                            begin
                                err_next       = 1'b1;
                                res.valid      = 1'b1;
                                res.item.kind  = hcbd_pkg::KIND_MALFORMED;
                            end
                            else if (acc_reg == '0)
                            begin
                                phase_next = PH_TRAILER;
                                tm_next    = hcbd_pkg::TM_START;
                            end
                            else if (TB'(acc_reg) > room)
                            begin
                                err_next       = 1'b1;
                                res.valid      = 1'b1;
                                res.item.kind  = hcbd_pkg::KIND_TOO_LARGE;
                            end
                            else
                            begin
                                total_next = total_reg + TB'(acc_reg);
                                left_next  = TB'(acc_reg);
                                phase_next = PH_DATA;
                            end
                        end
                        else
                        begin
                            crp_next = (b == hcbd_pkg::CHAR_CR);
                            if (!ended_reg)
                            begin
                                if (!hex.ok)
                                begin
                                    ended_next = 1'b1;
                                end
                                else
                                begin
                                    seen_next = 1'b1;
                                    if (!ovf_reg)
                                    begin
                                        if (acc_reg[SB-1 -: hcbd_pkg::DIGIT_BITS] != '0)
                                        begin
                                            ovf_next = 1'b1;
                                        end
                                        else
                                        begin
                                            acc_next = {acc_reg[SB-hcbd_pkg::DIGIT_BITS-1:0],
                                                        hex.value};
                                        end
                                    end
                                end
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        left_next = left_reg - TB'(1);
                        if (left_reg == TB'(1))
                        begin
                            phase_next = PH_CR;
                        end
                        res.valid          = 1'b1;
                        res.item.kind      = hcbd_pkg::KIND_BYTE;
                        res.item.data_byte = b;
                    end
                    PH_CR:
                    begin
                        if (b != hcbd_pkg::CHAR_CR)
                        begin
                            err_next      = 1'b1;
                            res.valid     = 1'b1;
                            res.item.kind = hcbd_pkg::KIND_MALFORMED;
                        end
                        else
                        begin
                            phase_next = PH_LF;
                        end
                    end
                    PH_LF:
                    begin
                        if (b != hcbd_pkg::CHAR_LF)
                        begin
                            err_next      = 1'b1;
                            res.valid     = 1'b1;
                            res.item.kind = hcbd_pkg::KIND_MALFORMED;
                        end
                        else
                        begin
                            phase_next = PH_SIZE;
                            acc_next   = '0;
                            ovf_next   = 1'b0;
                            seen_next  = 1'b0;
                            ended_next = 1'b0;
                            crp_next   = 1'b0;
                        end
                    end
                    PH_TRAILER:
                    begin
                        tm_next = tm_step;
                        if (tm_step == hcbd_pkg::TM_DONE)
                        begin
                            res.valid            = 1'b1;
                            res.item.kind        = hcbd_pkg::KIND_END;
                            res.item.body_length = hcbd_pkg::OUT_LEN_BITS'(total_reg);
                            phase_next = PH_SIZE;
                            acc_next   = '0;
                            ovf_next   = 1'b0;
                            seen_next  = 1'b0;
                            ended_next = 1'b0;
                            crp_next   = 1'b0;
                            left_next  = '0;
                            total_next = '0;
                            tm_next    = hcbd_pkg::TM_START;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_SIZE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIZE;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
            seen_reg  <= 1'b0;
            ended_reg <= 1'b0;
            crp_reg   <= 1'b0;
            left_reg  <= '0;
            total_reg <= '0;
            tm_reg    <= hcbd_pkg::TM_START;
            err_reg   <= 1'b0;
            cfg_reg   <= hcbd_pkg::CFG_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
            seen_reg  <= seen_next;
            ended_reg <= ended_next;
            crp_reg   <= crp_next;
            left_reg  <= left_next;
            total_reg <= total_next;
            tm_reg    <= tm_next;
            err_reg   <= err_next;
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
        end
    end

endmodule

// ===== rtl/hcbd_out_stage.sv =====
// ----------------------------------------------------------------------------
// Chunked body decoder result register
// Holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcbd_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  hcbd_pkg::out_item_t load_item,
    output logic                free,
    output logic                out_valid,
    input  logic                out_ready,
    output hcbd_pkg::out_item_t out_item
);

    logic                valid_reg;
    logic                valid_next;
    hcbd_pkg::out_item_t item_reg;

    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= load_item;
        end
    end

endmodule

// ===== rtl/http_chunked_body_decoder_core.sv =====
// ----------------------------------------------------------------------------
// Chunked body decoder top level
// Decodes an HTTP chunked body byte by byte into body bytes, message end and
// error items.
// ----------------------------------------------------------------------------
//  channel  | signals                         | handshake
//  ---------+---------------------------------+-------------------
//  input    | in_valid, in_ready, in_item     | valid/ready
//  output   | out_valid, out_ready, out_item  | valid/ready
//  config   | cfg_wr_en, cfg_wr_data          | write strobe, no wait
//
//  One item per cycle sustained while out_ready is high.
//  The parser steps on the input register and loads the result register.
//  Reset restores the size-line phase and a limit of 1048576 bytes.
//  A stalled result freezes the parser; the input register takes one item,
//  after which in_ready stays low until the result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "http_chunked_body_decoder_core_macros.svh"

module http_chunked_body_decoder_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  hcbd_pkg::in_item_t            in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output hcbd_pkg::out_item_t           out_item,
    input  logic                          cfg_wr_en,
    input  logic [hcbd_pkg::CFG_BITS-1:0] cfg_wr_data
);

    logic               held_valid;
    hcbd_pkg::in_item_t held_item;
    logic               out_free;
    logic               consume;
    hcbd_pkg::result_t  res;

    assign consume = held_valid && out_free;

    hcbd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .consume    (consume),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    hcbd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (consume),
        .item        (held_item),
        .res         (res)
    );

    hcbd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res.valid),
        .load_item (res.item),
        .free      (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    `HCBD_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")
    `HCBD_ASSERT_NOW(a_len_only_on_end, out_valid && out_item.kind != hcbd_pkg::KIND_END, out_item.body_length == '0, "length on non-end item")
    `HCBD_ASSERT_NOW(a_data_only_on_byte, out_valid && out_item.kind != hcbd_pkg::KIND_BYTE, out_item.data_byte == '0, "data on non-byte item")
    `HCBD_ASSERT_NEXT(a_no_result_idle, !held_valid && !out_valid, !out_valid, "result without item")

endmodule
